/* rtl/wrr_pkg.sv */
// Shared constants and types for the weighted round-robin scheduler.
package wrr_pkg;

  localparam int SLOTS       = 16;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int ID_W        = 16;
  localparam int WORK_W      = 16;
  localparam int WT_W        = 8;
  localparam int QUANT_W     = 10;
  localparam int LIMIT_W     = WT_W + QUANT_W;
  localparam int STATUS_W    = 2;
  localparam int JOBS_W      = 5;
  localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(10);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  localparam logic MODE_ADMIT = 1'b0;
  localparam logic MODE_SERVE = 1'b1;

  // Table update command from the control logic.
  typedef struct packed {
    logic              admit;
    logic              serve_keep;
    logic              serve_remove;
    logic [ID_W-1:0]   id;
    logic [WORK_W-1:0] work;
    logic [WT_W-1:0]   weight;
    logic [WORK_W-1:0] left;
  } tbl_upd_t;

  // Entry under the round-robin pointer.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [WORK_W-1:0] remaining;
    logic [WT_W-1:0]   weight;
  } tbl_head_t;

endpackage

/* rtl/wrr_if.sv */
// Valid/ready channel interfaces for scheduler commands and results.
interface wrr_in_if import wrr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ID_W-1:0]   job_id;
  logic [WORK_W-1:0] work_amount;
  logic [WT_W-1:0]   job_weight;

  modport source (output valid, mode, job_id, work_amount, job_weight, input ready);
  modport sink   (input valid, mode, job_id, work_amount, job_weight, output ready);
endinterface

interface wrr_out_if import wrr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     served_id;
  logic [WORK_W-1:0]   slice_length;
  logic [WORK_W-1:0]   work_left;
  logic                job_finished;
  logic [JOBS_W-1:0]   jobs_held;

  modport source (output valid, status, served_id, slice_length, work_left, job_finished,
                  jobs_held, input ready);
  modport sink   (input valid, status, served_id, slice_length, work_left, job_finished,
                  jobs_held, output ready);
endinterface

/* rtl/wrr_slice_calc.sv */
// Slice computation: min(remaining, weight * quantum) and the work left after it.
module wrr_slice_calc import wrr_pkg::*; (
  input  logic [WORK_W-1:0]  remaining_i,
  input  logic [WT_W-1:0]    weight_i,
  input  logic [QUANT_W-1:0] quantum_i,
  output logic [WORK_W-1:0]  slice_o,
  output logic [WORK_W-1:0]  left_o,
  output logic               finished_o
);

  logic [LIMIT_W-1:0] limit;

  assign limit      = LIMIT_W'(weight_i) * LIMIT_W'(quantum_i);
  assign slice_o    = (LIMIT_W'(remaining_i) < limit) ? remaining_i : limit[WORK_W-1:0];
  assign left_o     = remaining_i - slice_o;
  // Done only when a nonzero slice drained the job.
  assign finished_o = (left_o == '0) && (slice_o != '0);

endmodule

/* rtl/wrr_job_table.sv */
// Job table in admission order with round-robin pointer, job count and compaction.
module wrr_job_table import wrr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_upd_t         upd_i,
  output tbl_head_t        head_o,
  output logic [CNT_W-1:0] count_o
);

  logic [ID_W-1:0]   id_q   [SLOTS];
  logic [WORK_W-1:0] rem_q  [SLOTS];
  logic [WT_W-1:0]   wt_q   [SLOTS];
  logic [IDX_W-1:0]  ptr_q, ptr_d, ptr_eff;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_dec;

  assign ptr_eff = (CNT_W'(ptr_q) >= cnt_q) ? '0 : ptr_q;
  assign cnt_dec = cnt_q - CNT_W'(1);

  assign head_o.id        = id_q[ptr_eff];
  assign head_o.remaining = rem_q[ptr_eff];
  assign head_o.weight    = wt_q[ptr_eff];
  assign count_o          = cnt_q;

  always_comb begin
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    if (upd_i.admit) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (upd_i.serve_remove) begin
      // The next job slides into the current slot; wrap if it was the last one.
      cnt_d = cnt_dec;
      ptr_d = (CNT_W'(ptr_eff) < cnt_dec) ? ptr_eff : '0;
    end else if (upd_i.serve_keep) begin
      ptr_d = ((CNT_W'(ptr_eff) + CNT_W'(1)) < cnt_q) ? ptr_eff + IDX_W'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage: append at the tail, close up behind a removed job.
  always_ff @(posedge clk_i) begin
    if (upd_i.admit) begin
      id_q[cnt_q[IDX_W-1:0]]  <= upd_i.id;
      rem_q[cnt_q[IDX_W-1:0]] <= upd_i.work;
      wt_q[cnt_q[IDX_W-1:0]]  <= upd_i.weight;
    end else if (upd_i.serve_remove) begin
      for (int k = 0; k < SLOTS - 1; k++) begin
        if (IDX_W'(k) >= ptr_eff) begin
          id_q[k]  <= id_q[k+1];
          rem_q[k] <= rem_q[k+1];
          wt_q[k]  <= wt_q[k+1];
        end
      end
    end else if (upd_i.serve_keep) begin
      rem_q[ptr_eff] <= upd_i.left;
    end
  end

endmodule

/* rtl/weighted_round_robin_scheduler_core.sv */
// Weighted round-robin scheduler core: admits jobs and serves weighted time slices.
// The result of an input transfer appears in the output register in the following cycle.
// Throughput: one item per cycle; the table, pointer and count update in the same
// cycle, so the next item sees them. Input stalls only while a held result is not taken.
// Reset: pointer, job count and output valid clear, quantum returns to 10 ticks.
module weighted_round_robin_scheduler_core import wrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  wrr_in_if.sink             item_i,
  wrr_out_if.source          result_o,
  input  logic               cfg_we_i,
  input  logic [QUANT_W-1:0] cfg_wdata_i
);

  logic [QUANT_W-1:0] quantum_q;

  logic               accept;
  logic               full;
  logic               empty;
  tbl_upd_t           upd;
  tbl_head_t          head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_after;

  logic [WORK_W-1:0]  slice;
  logic [WORK_W-1:0]  left;
  logic               finished;

  status_e            status_d;
  logic [ID_W-1:0]    served_id_d;
  logic [WORK_W-1:0]  slice_d;
  logic [WORK_W-1:0]  left_d;
  logic               finished_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [ID_W-1:0]     served_id_q;
  logic [WORK_W-1:0]   slice_q;
  logic [WORK_W-1:0]   left_q;
  logic                finished_q;
  logic [JOBS_W-1:0]   jobs_held_q;

  // Base quantum register; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANT_RESET;
    end else if (cfg_we_i) begin
      quantum_q <= cfg_wdata_i;
    end
  end

  // Take a new item whenever the result register is empty or drains this cycle.
  assign item_i.ready = !out_valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;

  wrr_job_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .head_o  (head),
    .count_o (count)
  );

  wrr_slice_calc u_slice (
    .remaining_i (head.remaining),
    .weight_i    (head.weight),
    .quantum_i   (quantum_q),
    .slice_o     (slice),
    .left_o      (left),
    .finished_o  (finished)
  );

  assign full  = (count >= CNT_W'(SLOTS));
  assign empty = (count == '0);

  // Decode the item: pick status, result fields and the table update.
  always_comb begin
    upd          = '0;
    upd.id       = item_i.job_id;
    upd.work     = item_i.work_amount;
    upd.weight   = item_i.job_weight;
    upd.left     = left;
    status_d     = ST_OK;
    served_id_d  = '0;
    slice_d      = '0;
    left_d       = '0;
    finished_d   = 1'b0;
    if (item_i.mode == MODE_ADMIT) begin
      // Full table wins over a bad admission.
      if (full) begin
        status_d = ST_FULL;
      end else if (item_i.job_weight == '0 || item_i.work_amount == '0) begin
        status_d = ST_INVALID;
      end else begin
        upd.admit = accept;
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        served_id_d      = head.id;
        slice_d          = slice;
        left_d           = left;
        finished_d       = finished;
        upd.serve_remove = accept && finished;
        upd.serve_keep   = accept && !finished;
      end
    end
  end

  // Job count after this item, reported with the result.
  always_comb begin
    count_after = count;
    if (upd.admit) begin
      count_after = count + CNT_W'(1);
    end else if (upd.serve_remove) begin
      count_after = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result until its transfer; load on every accepted item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      served_id_q <= served_id_d;
      slice_q     <= slice_d;
      left_q      <= left_d;
      finished_q  <= finished_d;
      jobs_held_q <= JOBS_W'(count_after);
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = status_q;
  assign result_o.served_id    = served_id_q;
  assign result_o.slice_length = slice_q;
  assign result_o.work_left    = left_q;
  assign result_o.job_finished = finished_q;
  assign result_o.jobs_held    = jobs_held_q;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the weighted round-robin scheduler core.
module tb_top;
  import wrr_pkg::*;

  // One expected result of an admission or a serve.
  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     served_id;
    logic [WORK_W-1:0]   slice_length;
    logic [WORK_W-1:0]   work_left;
    logic                job_finished;
    logic [JOBS_W-1:0]   jobs_held;
  } grant_t;

  // Mirror of the job table; predicts one grant per accepted item and checks it.
  class slice_scoreboard;
    logic [QUANT_W-1:0] quantum;
    logic [ID_W-1:0]    tbl_id  [SLOTS];
    logic [WORK_W-1:0]  tbl_rem [SLOTS];
    logic [WT_W-1:0]    tbl_wt  [SLOTS];
    int unsigned        job_cnt;
    int unsigned        rr_ptr;
    grant_t             grants_due [$];
    int unsigned        mismatches;

    function new();
      quantum    = QUANT_RESET;
      job_cnt    = 0;
      rr_ptr     = 0;
      mismatches = 0;
    endfunction

    function void set_quantum(logic [QUANT_W-1:0] q);
      quantum = q;
    endfunction

    function int unsigned pending();
      return grants_due.size();
    endfunction

    function void note_item(logic mode, logic [ID_W-1:0] id, logic [WORK_W-1:0] work,
                            logic [WT_W-1:0] wt);
      grant_t             g;
      int unsigned        p;
      int unsigned        k;
      logic [LIMIT_W-1:0] limit;
      logic [WORK_W-1:0]  slice;
      g = '0;
      g.status = ST_OK;
      if (mode == MODE_ADMIT) begin
        // full takes precedence over a malformed admission
        if (job_cnt >= SLOTS) begin
          g.status = ST_FULL;
        end else if (wt == '0 || work == '0) begin
          g.status = ST_INVALID;
        end else begin
          tbl_id[job_cnt]  = id;
          tbl_rem[job_cnt] = work;
          tbl_wt[job_cnt]  = wt;
          job_cnt++;
        end
      end else if (job_cnt == 0) begin
        g.status = ST_EMPTY;
      end else begin
        if (rr_ptr >= job_cnt) rr_ptr = 0;
        p     = rr_ptr;
        limit = LIMIT_W'(tbl_wt[p]) * LIMIT_W'(quantum);
        slice = (LIMIT_W'(tbl_rem[p]) < limit) ? tbl_rem[p] : limit[WORK_W-1:0];
        g.served_id    = tbl_id[p];
        g.slice_length = slice;
        g.work_left    = tbl_rem[p] - slice;
        if (g.work_left == '0 && slice != '0) begin
          // close up behind the finished job; its successor takes slot p
          g.job_finished = 1'b1;
          for (k = p; k + 1 < job_cnt; k++) begin
            tbl_id[k]  = tbl_id[k+1];
            tbl_rem[k] = tbl_rem[k+1];
            tbl_wt[k]  = tbl_wt[k+1];
          end
          job_cnt--;
          rr_ptr = (p < job_cnt) ? p : 0;
        end else begin
          tbl_rem[p] = g.work_left;
          rr_ptr = (p + 1 < job_cnt) ? p + 1 : 0;
        end
      end
      g.jobs_held = JOBS_W'(job_cnt);
      grants_due = {grants_due, g};
    endfunction

    function void flag(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] id,
                               logic [WORK_W-1:0] slice, logic [WORK_W-1:0] left,
                               logic fin, logic [JOBS_W-1:0] held);
      grant_t g;
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0h id %0h",
                 $time, status, id);
        mismatches++;
        return;
      end
      g = grants_due.pop_front();
      flag("status",       16'(g.status),       16'(status));
      flag("served_id",    g.served_id,         id);
      flag("slice_length", g.slice_length,      slice);
      flag("work_left",    g.work_left,         left);
      flag("job_finished", 16'(g.job_finished), 16'(fin));
      flag("jobs_held",    16'(g.jobs_held),    16'(held));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [QUANT_W-1:0] cfg_wdata_i;
  bit                 no_gaps;

  wrr_in_if  item_if ();
  wrr_out_if res_if ();

  slice_scoreboard sb = new();

  weighted_round_robin_scheduler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .result_o    (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4000000;
    $display("FAIL weighted_round_robin_scheduler_core");
    $finish;
  end

  // Receiver: stall on about 16 percent of clocks, except during the gap-free stretch.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 16);
    end
  end

  // Check every result transfer against the oldest expected grant.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      sb.check_result(res_if.status, res_if.served_id, res_if.slice_length,
                      res_if.work_left, res_if.job_finished, res_if.jobs_held);
    end
  end

  // Present one item, idling at random first, and hold it until the transfer.
  // The prediction is made here so it is in place before any later drain check.
  task automatic send_item(logic mode, logic [ID_W-1:0] id, logic [WORK_W-1:0] work,
                           logic [WT_W-1:0] wt);
    while (!no_gaps && $urandom_range(0, 99) < 16) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.mode        <= mode;
    item_if.job_id      <= id;
    item_if.work_amount <= work;
    item_if.job_weight  <= wt;
    @(posedge clk_i);
    while (item_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_item(mode, id, work, wt);
  endtask

  // Hold the sender until every expected grant has come back, then settle.
  task automatic drain();
    item_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write the quantum only with the block idle.
  task automatic write_quantum(logic [QUANT_W-1:0] q);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= q;
    @(posedge clk_i);
    sb.set_quantum(q);
    cfg_we_i    <= 1'b0;
  endtask

  // Serve with random noise in the unused fields.
  task automatic serve_one();
    send_item(MODE_SERVE, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Random admission: mostly well formed, some zero fields, small weights common
  // so slices stay short enough for several serves per job.
  task automatic admit_random();
    logic [WORK_W-1:0] work;
    logic [WT_W-1:0]   wt;
    int unsigned       roll;
    roll = $urandom_range(0, 99);
    if (roll < 6)       work = '0;
    else if (roll < 21) work = 16'($urandom);
    else                work = 16'($urandom_range(1, 300));
    roll = $urandom_range(0, 99);
    if (roll < 6)       wt = '0;
    else if (roll < 55) wt = 8'($urandom_range(1, 8));
    else                wt = 8'($urandom_range(1, 255));
    send_item(MODE_ADMIT, 16'($urandom), work, wt);
  endtask

  initial begin
    logic [QUANT_W-1:0] phase_q [7];
    int unsigned        admit_pct;
    int unsigned        k;
    int unsigned        ph;

    // Drive every input to a known value and hold reset.
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    item_if.valid       <= 1'b0;
    item_if.mode        <= MODE_ADMIT;
    item_if.job_id      <= '0;
    item_if.work_amount <= '0;
    item_if.job_weight  <= '0;
    no_gaps             = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset quantum of 10 ticks.
    serve_one();                                    // serve on an empty table
    send_item(MODE_ADMIT, 16'h0001, 16'h0000, 8'h05); // zero work
    send_item(MODE_ADMIT, 16'h0002, 16'h0064, 8'h00); // zero weight
    send_item(MODE_ADMIT, 16'hFFFF, 16'hFFFF, 8'hFF); // all fields at maximum
    send_item(MODE_ADMIT, 16'h0000, 16'h0001, 8'h01); // smallest legal job
    serve_one();                                    // partial slice of the big job
    serve_one();                                    // finish the small job, wrap
    for (k = 0; k < 15; k++) begin
      send_item(MODE_ADMIT, 16'(16'h0100 + k), 16'(15 + 7 * k), 8'(1 + k));
    end
    send_item(MODE_ADMIT, 16'h0BAD, 16'h0000, 8'h00); // full beats malformed
    send_item(MODE_ADMIT, 16'h0ACE, 16'h0010, 8'h02); // full, well formed
    serve_one();
    serve_one();

    // Random phases, each at its own quantum: default, zero, the extremes, random, 512, small random.
    phase_q[0] = QUANT_RESET;
    phase_q[1] = '0;
    phase_q[2] = QUANT_W'(1);
    phase_q[3] = QUANT_W'(1023);
    phase_q[4] = QUANT_W'($urandom_range(2, 1022));
    phase_q[5] = QUANT_W'(512);
    phase_q[6] = QUANT_W'($urandom_range(1, 40));
    for (ph = 0; ph < 7; ph++) begin
      if (ph > 0) write_quantum(phase_q[ph]);
      // run one phase without any idling on either side
      no_gaps   = (ph == 3);
      admit_pct = $urandom_range(25, 75);
      for (k = 0; k < 136; k++) begin
        if ($urandom_range(0, 99) < admit_pct) admit_random();
        else serve_one();
        if ($urandom_range(0, 199) == 0) drain();
      end
      no_gaps = 1'b0;
    end

    drain();
    repeat (5) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS weighted_round_robin_scheduler_core");
    end else begin
      $display("FAIL weighted_round_robin_scheduler_core");
    end
    $finish;
  end

endmodule
